/* src/hftw_pkg.sv */
// Shared types and constants for the Huffman tree-walk decoder.
package hftw_pkg;

    localparam int IDX_W          = 9;
    localparam int SYM_W          = 8;
    localparam int BYTE_BITS      = 8;
    localparam int CNT_W          = 4;
    localparam int NODE_SLOTS_DEF = 512;
    localparam int OP_W           = 2;
    localparam int S_DATA_W       = 48;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
    localparam logic [OP_W-1:0] OP_END   = 2'd2;

    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_END    = 1'b1;

    typedef struct packed {
        logic             leaf;
        logic [SYM_W-1:0] symbol;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } node_t;

endpackage

/* src/huffman_tree_walk_decoder_unit.sv */
// Top level of the Huffman tree-walk decoder: node table, walk sequencer, output register.
//
// Requests enter on the s_axis group; opcode travels in s_axis_tuser. A node-write request
// stores one table entry. A data request decodes the byte held from
// the previous data request and then holds its own byte. An end request decodes the first
// min(count, 8) bits of the held byte, emits an end marker and returns the walk to the root.
// Results leave on the m_axis group: kind in m_axis_tuser, symbol in m_axis_tdata, and
// m_axis_tlast marks the final result of a request.
// Table reads go through a single registered read port. The sequencer accepts a request,
// fetches the current node, steps into its child when that node is internal, then walks
// the code bits, rereading the root after each leaf reached before the last bit, and
// finally flushes the final symbol and, for an end request, emits the end marker.
// s_axis_tready is high only while the sequencer is idle.
// Reset clears the walk position to node 0, the root register to 0 and the held byte;
// table contents are undefined until written. When the receiver stalls, the result in
// the output register holds and the walk waits for the next emitted symbol.
module huffman_tree_walk_decoder_unit #(
    parameter int NODE_SLOTS = hftw_pkg::NODE_SLOTS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // node_index[8:0], node_is_leaf[9], node_symbol[17:10], left_child[26:18],
    // right_child[35:27], stream_byte[43:36], zero fill [47:44]
    input  logic [hftw_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // opcode[1:0]
    input  logic [hftw_pkg::OP_W-1:0]        s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // symbol[7:0]
    output logic [hftw_pkg::SYM_W-1:0]       m_axis_tdata,
    // kind[0]
    output logic                             m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             cfg_we,
    input  logic [hftw_pkg::IDX_W-1:0]       cfg_wdata
);

    localparam int ADDR_W = (NODE_SLOTS > 2) ? $clog2(NODE_SLOTS) : 1;
    localparam int WIDE_W = (ADDR_W > hftw_pkg::IDX_W) ? ADDR_W : hftw_pkg::IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOOK_CUR,
        ST_LOOK_CHILD,
        ST_FLUSH,
        ST_END
    } state_t;

    state_t                        state_reg, state_next;
    logic [hftw_pkg::IDX_W-1:0]    root_reg;
    logic [hftw_pkg::IDX_W-1:0]    pos_reg, pos_next;
    logic [hftw_pkg::SYM_W-1:0]    held_byte_reg, held_byte_next;
    logic                          held_valid_reg, held_valid_next;
    logic [hftw_pkg::SYM_W-1:0]    work_byte_reg, work_byte_next;
    logic [hftw_pkg::CNT_W-1:0]    bits_left_reg, bits_left_next;
    logic                          end_reg, end_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [hftw_pkg::SYM_W-1:0]    pend_sym_reg, pend_sym_next;
    logic                          out_valid_reg, out_valid_next;
    logic [hftw_pkg::SYM_W-1:0]    out_sym_reg, out_sym_next;
    logic                          out_kind_reg, out_kind_next;
    logic                          out_last_reg, out_last_next;

    hftw_pkg::node_t               mem [NODE_SLOTS];
    hftw_pkg::node_t               rd_data_reg;
    logic                          rd_ok_reg;
    logic                          rd_en;
    logic [hftw_pkg::IDX_W-1:0]    rd_idx;
    logic                          wr_en;

    logic [hftw_pkg::IDX_W-1:0]    in_index;
    hftw_pkg::node_t               in_node;
    logic [hftw_pkg::SYM_W-1:0]    in_byte;
    logic [WIDE_W-1:0]             wr_wide;
    logic [WIDE_W-1:0]             rd_wide;
    logic                          wr_in_range;
    logic                          rd_in_range;

    hftw_pkg::node_t               entry;
    logic                          accept;
    logic                          out_free;
    logic                          can_emit;
    logic [hftw_pkg::IDX_W-1:0]    child_cur;
    logic [hftw_pkg::IDX_W-1:0]    child_nxt;
    logic [hftw_pkg::CNT_W-1:0]    end_count;

    assign in_index       = s_axis_tdata[8:0];
    assign in_node.leaf   = s_axis_tdata[9];
    assign in_node.symbol = s_axis_tdata[17:10];
    assign in_node.left   = s_axis_tdata[26:18];
    assign in_node.right  = s_axis_tdata[35:27];
    assign in_byte        = s_axis_tdata[43:36];

    assign wr_wide     = WIDE_W'(in_index);
    assign rd_wide     = WIDE_W'(rd_idx);
    assign wr_in_range = (32'(in_index) < 32'(NODE_SLOTS));
    assign rd_in_range = (32'(rd_idx) < 32'(NODE_SLOTS));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign wr_en         = accept && (s_axis_tuser == hftw_pkg::OP_WRITE) && wr_in_range;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sym_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    assign entry     = rd_ok_reg ? rd_data_reg : '0;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign can_emit  = !pend_valid_reg || out_free;
    assign child_cur = work_byte_reg[7] ? entry.right : entry.left;
    assign child_nxt = work_byte_reg[6] ? entry.right : entry.left;
    assign end_count = (in_byte > 8'(hftw_pkg::BYTE_BITS)) ?
                       hftw_pkg::CNT_W'(hftw_pkg::BYTE_BITS) : in_byte[hftw_pkg::CNT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_wide[ADDR_W-1:0]] <= in_node;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_wide[ADDR_W-1:0]];
            rd_ok_reg   <= rd_in_range;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        work_byte_next  = work_byte_reg;
        bits_left_next  = bits_left_reg;
        end_next        = end_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        out_valid_next  = out_valid_reg;
        out_sym_next    = out_sym_reg;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        rd_en           = 1'b0;
        rd_idx          = pos_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (s_axis_tuser)
                        hftw_pkg::OP_DATA:
                        begin
                            held_byte_next  = in_byte;
                            held_valid_next = 1'b1;
                            work_byte_next  = held_byte_reg;
                            bits_left_next  = hftw_pkg::CNT_W'(hftw_pkg::BYTE_BITS);
                            end_next        = 1'b0;
                            if (held_valid_reg)
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        hftw_pkg::OP_END:
                        begin
                            held_byte_next  = '0;
                            held_valid_next = 1'b0;
                            work_byte_next  = held_byte_reg;
                            bits_left_next  = end_count;
                            end_next        = 1'b1;
                            if (held_valid_reg && (end_count != '0))
                            begin
                                state_next = ST_FETCH;
                            end
                            else
                            begin
                                state_next = ST_FLUSH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                rd_en      = 1'b1;
                rd_idx     = pos_reg;
                state_next = ST_LOOK_CUR;
            end
            ST_LOOK_CUR, ST_LOOK_CHILD:
            begin
                if (entry.leaf)
                begin
                    if (can_emit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_sym_next   = pend_sym_reg;
                            out_kind_next  = hftw_pkg::KIND_SYMBOL;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sym_next   = entry.symbol;
                        pos_next        = root_reg;
                        work_byte_next  = {work_byte_reg[6:0], 1'b0};
                        bits_left_next  = bits_left_reg - hftw_pkg::CNT_W'(1);
                        if (bits_left_reg == hftw_pkg::CNT_W'(1))
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_idx     = root_reg;
                            state_next = ST_LOOK_CUR;
                        end
                    end
                end
                else if (state_reg == ST_LOOK_CUR)
                begin
                    pos_next   = child_cur;
                    rd_en      = 1'b1;
                    rd_idx     = child_cur;
                    state_next = ST_LOOK_CHILD;
                end
                else
                begin
                    work_byte_next = {work_byte_reg[6:0], 1'b0};
                    bits_left_next = bits_left_reg - hftw_pkg::CNT_W'(1);
                    if (bits_left_reg == hftw_pkg::CNT_W'(1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        pos_next   = child_nxt;
                        rd_en      = 1'b1;
                        rd_idx     = child_nxt;
                        state_next = ST_LOOK_CHILD;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_sym_next    = pend_sym_reg;
                        out_kind_next   = hftw_pkg::KIND_SYMBOL;
                        out_last_next   = !end_reg;
                        pend_valid_next = 1'b0;
                        state_next      = end_reg ? ST_END : ST_IDLE;
                    end
                end
                else
                begin
                    state_next = end_reg ? ST_END : ST_IDLE;
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = '0;
                    out_kind_next  = hftw_pkg::KIND_END;
                    out_last_next  = 1'b1;
                    pos_next       = root_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            root_reg       <= '0;
            pos_reg        <= '0;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            work_byte_reg  <= '0;
            bits_left_reg  <= '0;
            end_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_sym_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_sym_reg    <= '0;
            out_kind_reg   <= hftw_pkg::KIND_SYMBOL;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_we)
            begin
                root_reg <= cfg_wdata;
            end
            pos_reg        <= pos_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            work_byte_reg  <= work_byte_next;
            bits_left_reg  <= bits_left_next;
            end_reg        <= end_next;
            pend_valid_reg <= pend_valid_next;
            pend_sym_reg   <= pend_sym_next;
            out_valid_reg  <= out_valid_next;
            out_sym_reg    <= out_sym_next;
            out_kind_reg   <= out_kind_next;
            out_last_reg   <= out_last_next;
        end
    end

endmodule
